FILE: hw/rtl/hrlp_pkg.sv
// Shared types, constants and matcher functions of the HTTP request line parser.
package hrlp_pkg;

    // Byte codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    // Token set selectors
    localparam logic SET_METHOD  = 1'b0;
    localparam logic SET_VERSION = 1'b1;

    // Result codes
    localparam logic [1:0] CODE_NONE  = 2'd0;
    localparam logic [1:0] CODE_CAND0 = 2'd1;
    localparam logic [1:0] CODE_CAND1 = 2'd2;

    typedef enum logic [1:0] {
        PH_METHOD  = 2'd0,
        PH_URI     = 2'd1,
        PH_VERSION = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    // Matcher state of the current token
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [1:0]       flags;
    } match_t;

    typedef struct packed {
        phase_t     phase;
        match_t     match;
        logic       pending_cr;
        logic [1:0] method_seen;
        logic [1:0] version_seen;
    } parse_state_t;

    typedef struct packed {
        logic       uri_valid;
        logic [7:0] uri_byte;
        logic       uri_end;
        logic [1:0] method_code;
        logic [1:0] version_code;
        logic [1:0] phase;
        logic       line_done;
    } result_t;

    localparam match_t MATCH_INIT = '{pos: '0, flags: 2'b11};
    localparam parse_state_t STATE_INIT = '{
        phase: PH_METHOD, match: MATCH_INIT, pending_cr: 1'b0,
        method_seen: CODE_NONE, version_seen: CODE_NONE};

    // Candidate length: post 4, get 3, http/1.x 8
    function automatic logic [POS_W-1:0] cand_len(input logic set, input logic k);
        logic [POS_W-1:0] len;
        if (set == SET_VERSION)
            len = 4'd8;
        else if (k)
            len = 4'd3;
        else
            len = 4'd4;
        return len;
    endfunction

    // Candidate character at a given position (lower case)
    function automatic logic [7:0] cand_char(input logic set, input logic k,
                                             input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (set == SET_METHOD) begin
            if (!k) begin
                case (idx)
                    3'd0:    ch = "p";
                    3'd1:    ch = "o";
                    3'd2:    ch = "s";
                    3'd3:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            else begin
                case (idx)
                    3'd0:    ch = "g";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
        end
        else begin
            case (idx)
                3'd0:    ch = "h";
                3'd1:    ch = "t";
                3'd2:    ch = "t";
                3'd3:    ch = "p";
                3'd4:    ch = "/";
                3'd5:    ch = "1";
                3'd6:    ch = ".";
                default: ch = k ? "1" : "0";
            endcase
        end
        return ch;
    endfunction

    // Advance the matcher by one token character
    function automatic match_t feed(input logic set, input logic [7:0] b,
                                    input match_t m);
        match_t     r;
        logic [7:0] c;
        r = m;
        c = b;
        if (b >= CH_UP_A && b <= CH_UP_Z)
            c = b + CASE_OFS;
        for (int k = 0; k < 2; k++) begin
            if (!(m.pos < cand_len(set, k[0]) &&
                  cand_char(set, k[0], m.pos[2:0]) == c))
                r.flags[k] = 1'b0;
        end
        if (m.pos < POS_MAX)
            r.pos = m.pos + 1'b1;
        return r;
    endfunction

    // Code of a finished token
    function automatic logic [1:0] token_code(input logic set, input match_t m);
        logic [1:0] code;
        if (m.flags[0] && m.pos == cand_len(set, 1'b0))
            code = CODE_CAND0;
        else if (m.flags[1] && m.pos == cand_len(set, 1'b1))
            code = CODE_CAND1;
        else
            code = CODE_NONE;
        return code;
    endfunction

endpackage

FILE: hw/rtl/hrlp_if.sv
// Request and result channel interfaces of the HTTP request line parser.
interface hrlp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface hrlp_res_if;
    logic       valid;
    logic       ready;
    logic       uri_valid;
    logic [7:0] uri_byte;
    logic       uri_end;
    logic [1:0] method_code;
    logic [1:0] version_code;
    logic [1:0] phase;
    logic       line_done;

    modport source (output valid, output uri_valid, output uri_byte, output uri_end,
                    output method_code, output version_code, output phase,
                    output line_done, input ready);
    modport sink   (input valid, input uri_valid, input uri_byte, input uri_end,
                    input method_code, input version_code, input phase,
                    input line_done, output ready);
endinterface

FILE: hw/rtl/hrlp_step.sv
// Per-byte next-state and result logic of the request line parser.
module hrlp_step (
    input  hrlp_pkg::parse_state_t state_cur,
    input  logic [7:0]             data_byte,
    input  logic                   start_req,
    output hrlp_pkg::parse_state_t state_nxt,
    output hrlp_pkg::result_t      result
);
    import hrlp_pkg::*;

    parse_state_t st;
    parse_state_t nx;
    match_t       m;
    logic         uv;
    logic         ue;
    logic         ld;

    always_comb
    begin
        // A start request clears all parser state before this byte
        st = start_req ? STATE_INIT : state_cur;
        nx = st;
        m  = st.match;
        uv = 1'b0;
        ue = 1'b0;
        ld = 1'b0;
        unique case (st.phase)
            PH_METHOD:
            begin
                if (data_byte == CH_SPACE) begin
                    nx.method_seen = token_code(SET_METHOD, st.match);
                    nx.phase       = PH_URI;
                    nx.match       = MATCH_INIT;
                    nx.pending_cr  = 1'b0;
                end
                else begin
                    nx.match = feed(SET_METHOD, data_byte, st.match);
                end
            end
            PH_URI:
            begin
                if (data_byte == CH_SPACE) begin
                    ue            = 1'b1;
                    nx.phase      = PH_VERSION;
                    nx.match      = MATCH_INIT;
                    nx.pending_cr = 1'b0;
                end
                else begin
                    uv = 1'b1;
                end
            end
            PH_VERSION:
            begin
                if (st.pending_cr && data_byte == CH_LF) begin
                    nx.version_seen = token_code(SET_VERSION, st.match);
                    nx.phase        = PH_DONE;
                    nx.match        = MATCH_INIT;
                    nx.pending_cr   = 1'b0;
                    ld              = 1'b1;
                end
                else begin
                    // A lone CR counts as a token character
                    if (st.pending_cr)
                        m = feed(SET_VERSION, CH_CR, m);
                    if (data_byte == CH_CR) begin
                        nx.pending_cr = 1'b1;
                    end
                    else begin
                        nx.pending_cr = 1'b0;
                        m = feed(SET_VERSION, data_byte, m);
                    end
                    nx.match = m;
                end
            end
            PH_DONE:
            begin
                nx = st;
            end
            default:
            begin
                nx = st;
            end
        endcase
    end

    assign state_nxt           = nx;
    assign result.uri_valid    = uv;
    assign result.uri_byte     = uv ? data_byte : 8'h00;
    assign result.uri_end      = ue;
    assign result.method_code  = nx.method_seen;
    assign result.version_code = nx.version_seen;
    assign result.phase        = nx.phase;
    assign result.line_done    = ld;

endmodule

FILE: hw/rtl/http_request_line_parser_core.sv
// Top level of the HTTP request line parser: input register, parse step, result register.
// Path: a request accepted into the input register passes the parse step and is written
// to the result register once that register is empty or its result is being taken.
// Throughput: one byte per cycle, sustained while the result side keeps taking results.
// While a result waits, the input register still takes one request, then the input stalls.
// Reset (rst_n low, asynchronous) empties both stages; parser back to method phase, codes 0.
module http_request_line_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    hrlp_req_if.sink          req,
    hrlp_res_if.source        res
);
    import hrlp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;
    logic         out_valid_reg;
    result_t      out_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_next;
    logic         advance;

    // Stage handshake
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    hrlp_step u_step (
        .state_cur (state_reg),
        .data_byte (in_byte_reg),
        .start_req (in_start_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Control: stage valids and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_INIT;
        end
        else begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid) begin
            in_byte_reg  <= req.data_byte;
            in_start_reg <= req.start_req;
        end
        if (advance)
            out_reg <= result_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.uri_valid    = out_reg.uri_valid;
    assign res.uri_byte     = out_reg.uri_byte;
    assign res.uri_end      = out_reg.uri_end;
    assign res.method_code  = out_reg.method_code;
    assign res.version_code = out_reg.version_code;
    assign res.phase        = out_reg.phase;
    assign res.line_done    = out_reg.line_done;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench of the HTTP request line parser core.
`timescale 1ns / 1ps

module testbench;
    import hrlp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PRINT_LIMIT  = 40;

    logic clk;
    logic rst_n;

    hrlp_req_if req_ch ();
    hrlp_res_if res_ch ();

    http_request_line_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Parser state as the bench expects it
    phase_t     ps_phase;
    logic [3:0] ps_pos;
    logic [1:0] ps_flags;
    logic       ps_cr;
    logic [1:0] ps_method;
    logic [1:0] ps_version;

    result_t    expected_outputs[$];
    logic [7:0] pkt_q[$];

    int mismatches;
    int parsed_items;
    int outputs_checked;
    int lines_done;
    int post_lines;
    int get_lines;
    int v10_lines;
    int v11_lines;
    int burst_left;
    bit sender_steady;
    bit hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(6_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Expected behavior of the parser
    // ---------------------------------------------------------------
    function automatic logic [63:0] cand_text(input logic set, input int k);
        logic [63:0] txt;
        if (set == SET_VERSION)
        begin
            if (k == 0)
                txt = "http/1.0";
            else
                txt = "http/1.1";
        end
        else if (k == 0)
            txt = "post";
        else
            txt = "get";
        return txt;
    endfunction

    function automatic int cand_size(input logic set, input int k);
        if (set == SET_VERSION)
            return 8;
        return (k == 0) ? 4 : 3;
    endfunction

    function automatic void clear_parser();
        ps_phase   = PH_METHOD;
        ps_pos     = '0;
        ps_flags   = 2'b11;
        ps_cr      = 1'b0;
        ps_method  = CODE_NONE;
        ps_version = CODE_NONE;
    endfunction

    function automatic void start_token();
        ps_pos   = '0;
        ps_flags = 2'b11;
        ps_cr    = 1'b0;
    endfunction

    // One token character against both candidates of a set
    function automatic void feed_token_char(input logic set, input logic [7:0] b);
        logic [7:0]  c;
        logic [63:0] txt;
        int          n;
        int          sh;
        c = b;
        if (b >= CH_UP_A && b <= CH_UP_Z)
            c = b + CASE_OFS;
        for (int k = 0; k < 2; k++)
        begin
            n   = cand_size(set, k);
            txt = cand_text(set, k);
            if (int'(ps_pos) >= n)
                ps_flags[k] = 1'b0;
            else
            begin
                sh = 8 * (n - 1 - int'(ps_pos));
                if (txt[sh +: 8] != c)
                    ps_flags[k] = 1'b0;
            end
        end
        if (ps_pos != POS_MAX)
            ps_pos = ps_pos + 4'd1;
    endfunction

    function automatic logic [1:0] finished_code(input logic set);
        if (ps_flags[0] && int'(ps_pos) == cand_size(set, 0))
            return CODE_CAND0;
        if (ps_flags[1] && int'(ps_pos) == cand_size(set, 1))
            return CODE_CAND1;
        return CODE_NONE;
    endfunction

    function automatic result_t parse_next_byte(input logic [7:0] b, input logic s);
        result_t r;
        r = '0;
        if (s)
            clear_parser();
        case (ps_phase)
            PH_METHOD:
            begin
                if (b == CH_SPACE)
                begin
                    ps_method = finished_code(SET_METHOD);
                    ps_phase  = PH_URI;
                    start_token();
                end
                else
                    feed_token_char(SET_METHOD, b);
            end
            PH_URI:
            begin
                if (b == CH_SPACE)
                begin
                    r.uri_end = 1'b1;
                    ps_phase  = PH_VERSION;
                    start_token();
                end
                else
                begin
                    r.uri_valid = 1'b1;
                    r.uri_byte  = b;
                end
            end
            PH_VERSION:
            begin
                if (ps_cr && b == CH_LF)
                begin
                    ps_version  = finished_code(SET_VERSION);
                    ps_phase    = PH_DONE;
                    r.line_done = 1'b1;
                    start_token();
                    lines_done++;
                    if (ps_method == CODE_CAND0)
                        post_lines++;
                    if (ps_method == CODE_CAND1)
                        get_lines++;
                    if (ps_version == CODE_CAND0)
                        v10_lines++;
                    if (ps_version == CODE_CAND1)
                        v11_lines++;
                end
                else
                begin
                    // a CR that did not lead to LF is a token character
                    if (ps_cr)
                    begin
                        feed_token_char(SET_VERSION, CH_CR);
                        ps_cr = 1'b0;
                    end
                    if (b == CH_CR)
                        ps_cr = 1'b1;
                    else
                        feed_token_char(SET_VERSION, b);
                end
            end
            default:
            begin
            end
        endcase
        r.method_code  = ps_method;
        r.version_code = ps_version;
        r.phase        = ps_phase;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            gap = $urandom_range(6, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(24, 1);
        end
        if (burst_left != 0)
            burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.data_byte <= b;
        req_ch.start_req <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // bytes after a finished line do not count as parsed
        if (ps_phase != PH_DONE || s)
            parsed_items++;
        expected_outputs.push_back(parse_next_byte(b, s));
    endtask

    task automatic stop_sending();
        req_ch.valid <= 1'b0;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == 0);
    endtask

    task automatic wait_results_drained();
        int spins;
        spins = 0;
        while (expected_outputs.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (expected_outputs.size() != 0)
            report_mismatch("results never arrived", 8'd0, 8'(expected_outputs.size()));
    endtask

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if (b >= 8'h61 && b <= 8'h7A && $urandom_range(1, 0) == 1)
            return b - CASE_OFS;
        return b;
    endfunction

    function automatic void push_text(input string w, input bit vary);
        for (int i = 0; i < w.len(); i++)
            pkt_q.push_back(vary ? flip_case(w[i]) : w[i]);
    endfunction

    // Token byte: partly near the candidates, partly random letters and bytes, some edge values
    function automatic logic [7:0] pick_token_byte(input bit for_version);
        string      pool;
        string      edges;
        logic [7:0] b;
        pool  = "postgehp/1.01";
        edges = "@[`{AZaz";
        case ($urandom_range(9, 0))
            0, 1, 2: b = flip_case(pool[$urandom_range(pool.len() - 1, 0)]);
            3:       b = 8'($urandom_range(255, 0));
            4:       b = edges[$urandom_range(edges.len() - 1, 0)];
            5:       b = ($urandom_range(1, 0) == 1) ? 8'hFF : 8'h00;
            6:       b = ($urandom_range(1, 0) == 1) ? CH_CR : CH_LF;
            default: b = flip_case(8'(8'h61 + $urandom_range(25, 0)));
        endcase
        if (b == CH_SPACE && !for_version)
            b = "_";
        if (b == CH_CR && for_version)
            b = "r";
        return b;
    endfunction

    function automatic void push_rand_token(input int n, input bit for_version);
        for (int i = 0; i < n; i++)
            pkt_q.push_back(pick_token_byte(for_version));
    endfunction

    // Build one request line with random content into pkt_q
    function automatic void compose_request(input bit force_cut);
        int vstart;
        int pos;
        int keep;
        int ulen;
        pkt_q.delete();
        case ($urandom_range(6, 0))
            0:       push_text("post", 1);
            1:       push_text("get", 1);
            2:       push_text("pos", 1);
            3:       push_text("gets", 1);
            4:       push_text("postt", 1);
            5:       push_rand_token($urandom_range(18, 0), 0);
            default: push_text("get", 1);
        endcase
        pkt_q.push_back(CH_SPACE);
        ulen = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 0) : $urandom_range(8, 0);
        push_rand_token(ulen, 0);
        pkt_q.push_back(CH_SPACE);
        vstart = pkt_q.size();
        case ($urandom_range(7, 0))
            0, 1:    push_text("http/1.0", 1);
            2, 3:    push_text("http/1.1", 1);
            4:       push_text("http/1.", 1);
            5:       push_text("http/1.2", 1);
            6:       push_text("http/1.11", 1);
            default: push_rand_token($urandom_range(18, 0), 1);
        endcase
        // lone CR somewhere in the version token
        if ($urandom_range(5, 0) == 0)
        begin
            pos = $urandom_range(pkt_q.size(), vstart);
            pkt_q.insert(pos, CH_CR);
        end
        if ($urandom_range(9, 0) == 0)
            pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_LF);
        repeat ($urandom_range(2, 0)) pkt_q.push_back(8'($urandom_range(255, 0)));
        if (force_cut || $urandom_range(15, 0) == 0)
        begin
            keep = $urandom_range(pkt_q.size(), 1);
            while (pkt_q.size() > keep)
                void'(pkt_q.pop_back());
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(9, 0))
            0, 1:    b = CH_SPACE;
            2:       b = CH_CR;
            3:       b = CH_LF;
            default: b = 8'($urandom_range(255, 0));
        endcase
        return b;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left != 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(3, 0);
                    mode_left = $urandom_range(150, 20);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(1, 0) == 1);
                    2:       res_ch.ready <= ($urandom_range(3, 0) != 0);
                    default: res_ch.ready <= ((cyc % 8) < 5);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch("unexpected result, uri_byte", res_ch.uri_byte, 8'd0);
            else
            begin
                want = expected_outputs.pop_front();
                outputs_checked++;
                if (res_ch.uri_valid !== want.uri_valid)
                    report_mismatch("uri_valid", 8'(res_ch.uri_valid),
                                    8'(want.uri_valid));
                if (res_ch.uri_byte !== want.uri_byte)
                    report_mismatch("uri_byte", res_ch.uri_byte, want.uri_byte);
                if (res_ch.uri_end !== want.uri_end)
                    report_mismatch("uri_end", 8'(res_ch.uri_end), 8'(want.uri_end));
                if (res_ch.method_code !== want.method_code)
                    report_mismatch("method_code", 8'(res_ch.method_code),
                                    8'(want.method_code));
                if (res_ch.version_code !== want.version_code)
                    report_mismatch("version_code", 8'(res_ch.version_code),
                                    8'(want.version_code));
                if (res_ch.phase !== want.phase)
                    report_mismatch("phase", 8'(res_ch.phase), 8'(want.phase));
                if (res_ch.line_done !== want.line_done)
                    report_mismatch("line_done", 8'(res_ch.line_done),
                                    8'(want.line_done));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Mixed case, zero and all-ones bytes, CR in the URI, ignored tail,
    // empty tokens, and a lone CR followed by CR LF
    task automatic test_directed_bytes();
        pkt_q.delete();
        push_text("Post ", 0);
        pkt_q.push_back(8'h00);
        pkt_q.push_back(8'hFF);
        pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_SPACE);
        push_text("hTTp/1.0", 0);
        pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_LF);
        push_text("x", 0);
        send_packet();
        pkt_q.delete();
        pkt_q.push_back(CH_SPACE);
        pkt_q.push_back(CH_SPACE);
        pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_CR);
        pkt_q.push_back(CH_LF);
        send_packet();
    endtask

    task automatic test_wellformed_requests(input int count);
        int mark;
        mark = parsed_items;
        while (parsed_items - mark < count)
        begin
            if ($urandom_range(7, 0) == 0)
                sender_steady = !sender_steady;
            compose_request(1'b0);
            send_packet();
        end
        sender_steady = 1'b0;
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure(input int count);
        int mark;
        mark          = parsed_items;
        sender_steady = 1'b1;
        hold_request  = 1'b1;
        while (parsed_items - mark < count)
        begin
            compose_request(1'b0);
            send_packet();
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        repeat (3)
        begin
            compose_request(1'b0);
            send_packet();
        end
        stop_sending();
        wait_results_drained();
        repeat (3)
        begin
            compose_request(1'b0);
            send_packet();
        end
    endtask

    task automatic test_noise_and_broken(input int count);
        int mark;
        mark = parsed_items;
        while (parsed_items - mark < count)
        begin
            if ($urandom_range(1, 0) == 1)
            begin
                compose_request(1'b1);
                send_packet();
            end
            else
            begin
                repeat ($urandom_range(12, 1))
                    send_byte(noise_byte(), $urandom_range(19, 0) == 0);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        mismatches      = 0;
        parsed_items    = 0;
        outputs_checked = 0;
        lines_done      = 0;
        post_lines      = 0;
        get_lines       = 0;
        v10_lines       = 0;
        v11_lines       = 0;
        burst_left      = 0;
        sender_steady   = 1'b0;
        hold_request    = 1'b0;
        clear_parser();
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.data_byte <= 8'h00;
        req_ch.start_req <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_bytes();
        test_wellformed_requests(900);
        test_output_backpressure(80);
        test_pause_until_drained();
        test_noise_and_broken(330);

        stop_sending();
        wait_results_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d parsed bytes; %0d request lines completed.",
                 outputs_checked, parsed_items, lines_done);
        $display("Lines with post %0d, get %0d, http/1.0 %0d, http/1.1 %0d; mismatches %0d.",
                 post_lines, get_lines, v10_lines, v11_lines, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
